>>> design/ptms_pkg.sv
// ----------------------------------------------------------------------------
// ptms_pkg
// Shared types and constants of the priority task message scheduler.
// ----------------------------------------------------------------------------
package ptms_pkg;

    // default sizes
    localparam int MAX_TASKS_DEF     = 8;
    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int PRIORITY_BITS_DEF = 4;

    // configuration register indexes
    localparam logic CFG_TASK_COUNT = 1'b0;
    localparam logic CFG_TASK_PRIO  = 1'b1;

    typedef enum logic [1:0] {
        KIND_POST_MSG  = 2'd0,
        KIND_POST_TASK = 2'd1,
        KIND_DISPATCH  = 2'd2,
        KIND_REMOVE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_ID = 2'd1,
        ST_ACTIVE = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // classified command from the front end
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  task_id;
        logic [7:0]  sig;
        logic        bad_id;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic        dispatched;
        logic [2:0]  out_task;
        logic [7:0]  out_signal;
        logic        removed;
        t_status     status;
    } t_result;

endpackage

>>> design/ptms_ram.sv
// ----------------------------------------------------------------------------
// ptms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/ptms_front.sv
// ----------------------------------------------------------------------------
// ptms_front
// Input side: takes commands, checks the task id, holds them in a
// two-entry queue for the execution engine.
// ----------------------------------------------------------------------------
module ptms_front #(
    parameter int MAX_TASKS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     i_kind,
    input  logic [2:0]     i_task_id,
    input  logic [7:0]     i_signal,
    input  logic [3:0]     i_task_count,
    output logic           o_cmd_valid,
    output ptms_pkg::t_cmd o_cmd,
    input  logic           i_cmd_take
);
    import ptms_pkg::*;

    localparam int NW = ($clog2(MAX_TASKS + 1) > 4) ? $clog2(MAX_TASKS + 1) : 4;

    t_cmd        r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic [NW-1:0] n_limit;
    t_cmd        n_cmd;
    logic        n_push;
    logic        n_take;

    // task id check against min(task_count, MAX_TASKS)
    always_comb begin
        n_limit = (NW'(i_task_count) < NW'(MAX_TASKS)) ? NW'(i_task_count)
                                                        : NW'(MAX_TASKS);
        n_cmd.kind    = t_kind'(i_kind);
        n_cmd.task_id = i_task_id;
        n_cmd.sig     = i_signal;
        n_cmd.bad_id  = !(NW'(i_task_id) < n_limit);
    end

    assign full        = (r_cnt == 2'd2);
    assign n_push      = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign n_take      = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_push) begin
                r_wp <= !r_wp;
            end
            if (n_take) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(n_push) - 2'(n_take);
        end
    end

endmodule

>>> design/ptms_back.sv
// ----------------------------------------------------------------------------
// ptms_back
// Execution engine: ready list, per-task message queues, dispatch and
// remove walks, result register.
// ----------------------------------------------------------------------------
module ptms_back #(
    parameter int MAX_TASKS     = 8,
    parameter int QUEUE_DEPTH   = 8,
    parameter int PRIORITY_BITS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_task_prio,
    input  logic              i_cmd_valid,
    input  ptms_pkg::t_cmd    i_cmd,
    output logic              o_cmd_take,
    output logic              o_res_valid,
    output ptms_pkg::t_result o_res,
    input  logic              i_res_pop
);
    import ptms_pkg::*;

    localparam int TW = $clog2(MAX_TASKS);
    localparam int LW = $clog2(MAX_TASKS + 1);
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(2 * QUEUE_DEPTH);
    localparam int AW = $clog2(MAX_TASKS * QUEUE_DEPTH);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_EXEC   = 10'b0000000010,
        S_INS    = 10'b0000000100,
        S_APPEND = 10'b0000001000,
        S_DISP   = 10'b0000010000,
        S_DRD    = 10'b0000100000,
        S_RMRD   = 10'b0001000000,
        S_RMCMP  = 10'b0010000000,
        S_SHRD   = 10'b0100000000,
        S_SHWR   = 10'b1000000000
    } t_state;

    t_state          r_state;
    t_cmd            r_cmd;
    t_result         r_out;
    logic            r_out_valid;
    logic [TW-1:0]   r_order [MAX_TASKS];
    logic [LW-1:0]   r_rcount;
    logic            r_active [MAX_TASKS];
    logic            r_run_valid;
    logic [TW-1:0]   r_run_task;
    logic [HW-1:0]   r_head [MAX_TASKS];
    logic [FW-1:0]   r_fill [MAX_TASKS];
    logic [LW-1:0]   r_pos;
    logic [FW-1:0]   r_k;

    logic [TW-1:0]   n_tid;
    logic            n_we;
    logic [AW-1:0]   n_waddr;
    logic [AW-1:0]   n_raddr;
    logic [7:0]      rd_data;

    // priority of a task; bits beyond the register read as zero
    function automatic logic [PRIORITY_BITS-1:0] prio_of(input logic [TW-1:0] t);
        logic [63:0] ext;
        ext = {32'd0, i_task_prio} >> (t * PRIORITY_BITS);
        return ext[PRIORITY_BITS-1:0];
    endfunction

    // message store address of entry off of task t's circular queue
    function automatic logic [AW-1:0] slot(input logic [TW-1:0] t,
                                           input logic [FW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(r_head[t]) + SW'(off);
        if (s >= SW'(QUEUE_DEPTH)) begin
            s = s - SW'(QUEUE_DEPTH);
        end
        return AW'(t) * AW'(QUEUE_DEPTH) + AW'(s);
    endfunction

    assign n_tid       = TW'(r_cmd.task_id);
    assign o_cmd_take  = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || i_res_pop);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // message store ports
    always_comb begin
        n_we    = 1'b0;
        n_waddr = slot(n_tid, r_fill[n_tid]);
        n_raddr = slot(n_tid, r_k);
        unique case (r_state)
            S_APPEND: n_we = 1'b1;
            S_SHWR: begin
                n_we    = 1'b1;
                n_waddr = slot(n_tid, r_k);
            end
            S_DISP:   n_raddr = slot(r_run_task, '0);
            S_SHRD:   n_raddr = slot(n_tid, r_k + FW'(1));
            default: ;
        endcase
    end

    ptms_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TASKS * QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_we && r_state == S_SHWR ? rd_data : r_cmd.sig),
        .i_raddr (n_raddr),
        .o_rdata (rd_data)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rcount    <= '0;
            r_run_valid <= 1'b0;
            r_run_task  <= '0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_active[i] <= 1'b0;
                r_head[i]   <= '0;
                r_fill[i]   <= '0;
            end
        end else begin
            if (i_res_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_cmd   <= i_cmd;
                        r_out   <= '{dispatched: 1'b0, out_task: 3'd0, out_signal: 8'd0,
                                     removed: 1'b0, status: ST_OK};
                        r_pos   <= '0;
                        r_k     <= '0;
                        r_state <= S_EXEC;
                    end
                end
                // classify and check
                S_EXEC: begin
                    unique case (r_cmd.kind)
                        KIND_POST_MSG: begin
                            if (r_cmd.bad_id) begin
                                r_out.status <= ST_BAD_ID;
                                r_out_valid  <= 1'b1;
                                r_state      <= S_IDLE;
                            end else if (r_fill[n_tid] >= FW'(QUEUE_DEPTH)) begin
                                r_out.status <= ST_FULL;
                                r_out_valid  <= 1'b1;
                                r_state      <= S_IDLE;
                            end else if (!r_active[n_tid]) begin
                                r_active[n_tid] <= 1'b1;
                                r_state <= (r_rcount < LW'(MAX_TASKS)) ? S_INS : S_APPEND;
                            end else begin
                                r_state <= S_APPEND;
                            end
                        end
                        KIND_POST_TASK: begin
                            if (r_cmd.bad_id) begin
                                r_out.status <= ST_BAD_ID;
                                r_out_valid  <= 1'b1;
                                r_state      <= S_IDLE;
                            end else if (r_active[n_tid]) begin
                                r_out.status <= ST_ACTIVE;
                                r_out_valid  <= 1'b1;
                                r_state      <= S_IDLE;
                            end else begin
                                r_active[n_tid] <= 1'b1;
                                if (r_rcount < LW'(MAX_TASKS)) begin
                                    r_state <= S_INS;
                                end else begin
                                    r_out_valid <= 1'b1;
                                    r_state     <= S_IDLE;
                                end
                            end
                        end
                        KIND_DISPATCH: r_state <= S_DISP;
                        KIND_REMOVE: begin
                            if (r_cmd.bad_id) begin
                                r_out.status <= ST_BAD_ID;
                                r_out_valid  <= 1'b1;
                                r_state      <= S_IDLE;
                            end else begin
                                r_state <= S_RMRD;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                // sorted insertion: walk past entries of equal or higher priority
                S_INS: begin
                    if (r_pos < r_rcount &&
                        prio_of(r_order[r_pos[TW-1:0]]) >= prio_of(n_tid)) begin
                        r_pos <= r_pos + LW'(1);
                    end else begin
                        for (int i = 0; i < MAX_TASKS; i++) begin
                            if (LW'(i) > r_pos && LW'(i) <= r_rcount) begin
                                r_order[i] <= r_order[(i > 0) ? i - 1 : 0];
                            end else if (LW'(i) == r_pos) begin
                                r_order[i] <= n_tid;
                            end
                        end
                        r_rcount <= r_rcount + LW'(1);
                        if (r_cmd.kind == KIND_POST_MSG) begin
                            r_state <= S_APPEND;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                // append signal to the task queue
                S_APPEND: begin
                    r_fill[n_tid] <= r_fill[n_tid] + FW'(1);
                    r_out_valid   <= 1'b1;
                    r_state       <= S_IDLE;
                end
                // dispatch: drain running task, else take the list head
                S_DISP: begin
                    if (r_run_valid) begin
                        if (r_fill[r_run_task] != '0) begin
                            r_state <= S_DRD;
                        end else begin
                            r_active[r_run_task] <= 1'b0;
                            r_run_valid          <= 1'b0;
                        end
                    end else if (r_rcount == '0) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_run_task  <= r_order[0];
                        r_run_valid <= 1'b1;
                        for (int i = 0; i < MAX_TASKS - 1; i++) begin
                            r_order[i] <= r_order[i + 1];
                        end
                        r_rcount <= r_rcount - LW'(1);
                    end
                end
                S_DRD: begin
                    r_head[r_run_task] <= (r_head[r_run_task] == HW'(QUEUE_DEPTH - 1))
                                          ? '0 : r_head[r_run_task] + HW'(1);
                    r_fill[r_run_task] <= r_fill[r_run_task] - FW'(1);
                    r_out.dispatched   <= 1'b1;
                    r_out.out_task     <= 3'(r_run_task);
                    r_out.out_signal   <= rd_data;
                    r_out_valid        <= 1'b1;
                    r_state            <= S_IDLE;
                end
                // remove: search for the first matching signal
                S_RMRD: begin
                    if (r_k < r_fill[n_tid]) begin
                        r_state <= S_RMCMP;
                    end else begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_RMCMP: begin
                    if (rd_data == r_cmd.sig) begin
                        r_state <= S_SHRD;
                    end else begin
                        r_k     <= r_k + FW'(1);
                        r_state <= S_RMRD;
                    end
                end
                // close the gap one entry at a time
                S_SHRD: begin
                    if (r_k + FW'(1) < r_fill[n_tid]) begin
                        r_state <= S_SHWR;
                    end else begin
                        r_fill[n_tid] <= r_fill[n_tid] - FW'(1);
                        r_out.removed <= 1'b1;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                S_SHWR: begin
                    r_k     <= r_k + FW'(1);
                    r_state <= S_SHRD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/priority_task_message_scheduler_unit.sv
// Posts of a task or message walk the sorted insertion into the ready list,
// a dispatch steps through the ready list, and a remove searches and shifts
// the entries of the task's message queue.
// Flow: one command at a time in the execution engine; a two-entry
// command queue and a result register keep both sides decoupled.
// Reset: synchronous, clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
// priority_task_message_scheduler_unit
// Priority ready list of tasks with per-task message queues.
// ----------------------------------------------------------------------------
module priority_task_message_scheduler_unit #(
    parameter int MAX_TASKS     = ptms_pkg::MAX_TASKS_DEF,
    parameter int QUEUE_DEPTH   = ptms_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIORITY_BITS = ptms_pkg::PRIORITY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_task_id,
    input  logic [7:0]  i_signal,
    output logic        empty,
    input  logic        pop,
    output logic        o_dispatched,
    output logic [2:0]  o_out_task,
    output logic [7:0]  o_out_signal,
    output logic        o_removed,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);
    import ptms_pkg::*;

    logic [3:0]  r_task_count;
    logic [31:0] r_task_prio;
    logic        cmd_valid;
    logic        cmd_take;
    t_cmd        cmd;
    logic        res_valid;
    t_result     res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= '0;
            r_task_prio  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TASK_COUNT: r_task_count <= i_cfg_wdata[3:0];
                CFG_TASK_PRIO:  r_task_prio  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    ptms_front #(
        .MAX_TASKS (MAX_TASKS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_task_id    (i_task_id),
        .i_signal     (i_signal),
        .i_task_count (r_task_count),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_take   (cmd_take)
    );

    ptms_back #(
        .MAX_TASKS     (MAX_TASKS),
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_task_prio (r_task_prio),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    // result transfer
    assign empty        = !res_valid;
    assign o_dispatched = res.dispatched;
    assign o_out_task   = res.out_task;
    assign o_out_signal = res.out_signal;
    assign o_removed    = res.removed;
    assign o_status     = res.status;

endmodule

>>> verif/tb_priority_task_message_scheduler_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_task_message_scheduler_unit
// Drives post, dispatch and remove commands into the scheduler under several
// task counts and priority maps. Each result is checked against a scoreboard
// that tracks the ready list and the message queues of every task.
// ----------------------------------------------------------------------------
module tb_priority_task_message_scheduler_unit;
    import ptms_pkg::*;

    localparam int NTASK    = 8;
    localparam int QDEPTH   = 8;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] task_id;
        logic [7:0] sig;
    } t_cmd_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_kind = '0;
    logic [2:0]  i_task_id = '0;
    logic [7:0]  i_signal = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_dispatched;
    logic [2:0]  o_out_task;
    logic [7:0]  o_out_signal;
    logic        o_removed;
    logic [1:0]  o_status;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    priority_task_message_scheduler_unit i_dut (.*);

    // clock
    always #6 i_clk = ~i_clk;

    // scoreboard copy of scheduler state
    logic [3:0]  sb_task_count;
    logic [31:0] sb_prio;
    logic [2:0]  sb_ready [NTASK];
    int          sb_ready_n;
    logic        sb_active [NTASK];
    logic        sb_run_valid;
    logic [2:0]  sb_run_task;
    logic [7:0]  sb_msgs [NTASK][$];

    t_cmd_item   cmd_q [$];
    t_result     result_q [$];
    int          n_fail = 0;
    int          n_sent = 0;
    int          n_got = 0;
    int          n_disp = 0;
    int          n_rm = 0;
    int          idle_cnt = 0;

    function automatic logic [3:0] prio_of(logic [2:0] t);
        return sb_prio[t*4 +: 4];
    endfunction

    function automatic bit id_valid(logic [2:0] t);
        int lim;
        lim = (sb_task_count < NTASK) ? sb_task_count : NTASK;
        return t < lim;
    endfunction

    function automatic void ready_insert(logic [2:0] t);
        int pos;
        pos = 0;
        sb_active[t] = 1'b1;
        if (sb_ready_n >= NTASK) return;
        while (pos < sb_ready_n && prio_of(sb_ready[pos]) >= prio_of(t)) pos++;
        for (int i = sb_ready_n; i > pos; i--) sb_ready[i] = sb_ready[i-1];
        sb_ready[pos] = t;
        sb_ready_n++;
    endfunction

    // compute the expected result of one command and update the scoreboard
    function automatic t_result schedule_step(t_cmd_item c);
        t_result r;
        logic [2:0] t;
        r = '0;
        r.status = ST_OK;
        t = c.task_id;
        case (c.kind)
            KIND_POST_MSG: begin
                if (!id_valid(t)) r.status = ST_BAD_ID;
                else if (sb_msgs[t].size() >= QDEPTH) r.status = ST_FULL;
                else begin
                    if (!sb_active[t]) ready_insert(t);
                    sb_msgs[t].push_back(c.sig);
                end
            end
            KIND_POST_TASK: begin
                if (!id_valid(t)) r.status = ST_BAD_ID;
                else if (sb_active[t]) r.status = ST_ACTIVE;
                else ready_insert(t);
            end
            KIND_DISPATCH: begin
                for (int it = 0; it < 2*NTASK + 2; it++) begin
                    if (sb_run_valid) begin
                        if (sb_msgs[sb_run_task].size() > 0) begin
                            r.out_signal = sb_msgs[sb_run_task].pop_front();
                            r.out_task = sb_run_task;
                            r.dispatched = 1'b1;
                            break;
                        end
                        sb_active[sb_run_task] = 1'b0;
                        sb_run_valid = 1'b0;
                    end else begin
                        if (sb_ready_n == 0) break;
                        sb_run_task = sb_ready[0];
                        sb_run_valid = 1'b1;
                        for (int j = 1; j < sb_ready_n; j++) sb_ready[j-1] = sb_ready[j];
                        sb_ready_n--;
                    end
                end
            end
            default: begin
                if (!id_valid(t)) r.status = ST_BAD_ID;
                else begin
                    foreach (sb_msgs[t][k]) begin
                        if (sb_msgs[t][k] == c.sig) begin
                            sb_msgs[t].delete(k);
                            r.removed = 1'b1;
                            break;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // driver: transfers queued commands, predicts on acceptance
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                result_q.push_back(schedule_step(
                    t_cmd_item'{t_kind'(i_kind), i_task_id, i_signal}));
                n_sent++;
            end
            if (!(push && full)) begin
                if (drv_gap > 0 || cmd_q.size() == 0) begin
                    push <= 1'b0;
                    if (drv_gap > 0) drv_gap <= drv_gap - 1;
                end else begin
                    t_cmd_item c;
                    c = cmd_q.pop_front();
                    push      <= 1'b1;
                    i_kind    <= c.kind;
                    i_task_id <= c.task_id;
                    i_signal  <= c.sig;
                    drv_gap   <= gap_len();
                end
            end
        end
    end

    // monitor: checks each result transfer against the oldest expectation
    int pop_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                t_result e;
                n_got++;
                if (result_q.size() == 0) begin
                    $error("result with no expectation waiting");
                    n_fail++;
                end else begin
                    e = result_q.pop_front();
                    if (o_dispatched !== e.dispatched) begin
                        $error("dispatched exp %0d got %0d", e.dispatched, o_dispatched);
                        n_fail++;
                    end
                    if (o_out_task !== e.out_task) begin
                        $error("out_task exp %0d got %0d", e.out_task, o_out_task);
                        n_fail++;
                    end
                    if (o_out_signal !== e.out_signal) begin
                        $error("out_signal exp %0h got %0h", e.out_signal, o_out_signal);
                        n_fail++;
                    end
                    if (o_removed !== e.removed) begin
                        $error("removed exp %0d got %0d", e.removed, o_removed);
                        n_fail++;
                    end
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status);
                        n_fail++;
                    end
                    if (e.dispatched) n_disp++;
                    if (e.removed) n_rm++;
                end
            end
            if (pop_gap > 0) begin
                pop <= 1'b0;
                pop_gap <= pop_gap - 1;
            end else begin
                pop <= 1'b1;
                pop_gap <= (pop && !empty) ? gap_len() : 0;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT) begin
            $display("tb_priority_task_message_scheduler_unit NOT OK");
            $finish;
        end
    end

    task automatic wait_drained();
        while (cmd_q.size() != 0 || push || result_q.size() != 0) @(posedge i_clk);
        repeat (2*NTASK + 10) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic addr, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (addr == CFG_TASK_COUNT) sb_task_count = data[3:0];
        else sb_prio = data;
    endtask

    function automatic void add_cmd(t_kind k, int t, int s);
        cmd_q.push_back(t_cmd_item'{k, 3'(t), 8'(s)});
    endfunction

    // random mix: mostly posts and dispatches on valid ids, some noise
    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            int p, t, s;
            p = $urandom_range(99);
            t = ($urandom_range(9) == 0 || sb_task_count == 0)
                ? $urandom_range(7) : $urandom_range(sb_task_count - 1 > 7 ? 7
                : sb_task_count - 1);
            s = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7);
            if (p < 40) add_cmd(KIND_POST_MSG, t, s);
            else if (p < 50) add_cmd(KIND_POST_TASK, t, s);
            else if (p < 85) add_cmd(KIND_DISPATCH, $urandom_range(7), $urandom_range(255));
            else add_cmd(KIND_REMOVE, t, s);
        end
    endtask

    initial begin
        sb_task_count = '0;
        sb_prio = '0;
        sb_ready_n = 0;
        sb_run_valid = 1'b0;
        sb_run_task = '0;
        foreach (sb_active[i]) sb_active[i] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // task count zero: every targeted op has a bad id
        add_cmd(KIND_POST_MSG, 0, 8'h11);
        add_cmd(KIND_DISPATCH, 0, 0);
        wait_drained();

        // directed: full count, mixed priorities
        cfg_write(CFG_TASK_COUNT, 32'd8);
        cfg_write(CFG_TASK_PRIO, 32'hF0A5_5A0F);
        add_cmd(KIND_POST_MSG, 0, 8'h00);
        add_cmd(KIND_POST_MSG, 7, 8'hFF);
        add_cmd(KIND_POST_TASK, 7, 8'h00);    // already active
        add_cmd(KIND_POST_TASK, 3, 8'h00);    // activated without messages
        add_cmd(KIND_POST_MSG, 5, 8'hA5);
        for (int i = 0; i < 9; i++) add_cmd(KIND_POST_MSG, 2, i); // ninth is full
        add_cmd(KIND_REMOVE, 2, 4);
        add_cmd(KIND_REMOVE, 2, 8'h77);       // no match
        add_cmd(KIND_REMOVE, 6, 8'h00);       // empty queue
        for (int i = 0; i < 12; i++) add_cmd(KIND_DISPATCH, 0, 0);
        wait_drained();

        // bad id above count, equal priorities
        cfg_write(CFG_TASK_COUNT, 32'd3);
        cfg_write(CFG_TASK_PRIO, 32'h0000_0000);
        add_cmd(KIND_POST_MSG, 3, 8'h5A);
        add_cmd(KIND_REMOVE, 7, 8'h5A);
        add_cmd(KIND_POST_TASK, 4, 0);
        random_phase(300);
        wait_drained();

        cfg_write(CFG_TASK_COUNT, 32'd15);
        cfg_write(CFG_TASK_PRIO, 32'hFFFF_FFFF);
        random_phase(300);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            cfg_write(CFG_TASK_COUNT, $urandom_range(15, 2));
            cfg_write(CFG_TASK_PRIO, $urandom());
            random_phase(200);
            // priorities change while tasks stay listed
            wait_drained();
            cfg_write(CFG_TASK_PRIO, $urandom());
        end
        cfg_write(CFG_TASK_COUNT, 32'd1);
        random_phase(40);
        wait_drained();

        $display("sent %0d commands, checked %0d results", n_sent, n_got);
        $display("%0d dispatched messages, %0d removals", n_disp, n_rm);
        if (n_fail == 0) begin
            $display("tb_priority_task_message_scheduler_unit OK");
        end else begin
            $display("tb_priority_task_message_scheduler_unit NOT OK");
        end
        $finish;
    end

endmodule
